// ----- rtl/dmart_pkg.sv -----
// ----------------------------------------------------------------------------
// dmart_pkg
// Shared types and constants for the short/long moving-average RSSI trigger.
// ----------------------------------------------------------------------------
`default_nettype none

package dmart_pkg;

   // Field widths
   localparam int SAMPLE_W   = 8;
   localparam int RATIO_W    = 10;
   localparam int CHAN_W     = 5;
   localparam int CSR_DATA_W = 10;
   localparam int CSR_IDX_W  = 1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [RATIO_W-1:0]         ratio_type;
   typedef logic [CHAN_W-1:0]          chan_type;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RATIO_Q8       = 1'b0,
      CSR_TARGET_CHANNEL = 1'b1
   } csr_index_type;

   // Register reset values
   localparam ratio_type RATIO_RESET  = 10'd282;
   localparam chan_type  TARGET_RESET = 5'd17;

   // Per-window control from the top level
   typedef struct packed {
      logic push;       // an item is accepted this cycle
      logic old_valid;  // the entry being replaced has been written
   } window_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/dmart_ifs.sv -----
// ----------------------------------------------------------------------------
// dmart_req_if / dmart_rsp_if
// Valid/ready channels for sample items and trigger result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmart_req_if;
   logic                   valid;
   logic                   ready;
   dmart_pkg::sample_type  rssi_sample;

   modport source (output valid, output rssi_sample, input ready);
   modport sink   (input valid, input rssi_sample, output ready);
endinterface

interface dmart_rsp_if;
   logic                   valid;
   logic                   ready;
   dmart_pkg::sample_type  short_avg;
   dmart_pkg::sample_type  long_avg;
   logic                   switch_now;
   dmart_pkg::chan_type    channel_out;

   modport source (output valid, output short_avg, output long_avg,
                   output switch_now, output channel_out, input ready);
   modport sink   (input valid, input short_avg, input long_avg,
                   input switch_now, input channel_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/dmart_ram.sv -----
// ----------------------------------------------------------------------------
// dmart_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dmart_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 100,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/dmart_window.sv -----
// ----------------------------------------------------------------------------
// dmart_window
// Ring of samples in a RAM with a running sum. The entry to be replaced next
// is read ahead from the RAM, so the sum updates in the accepting cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dmart_window #(
   parameter int LEN = 20,
   localparam int SUM_W = dmart_pkg::SAMPLE_W + $clog2(LEN)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dmart_pkg::window_ctl_type ctl,
   input  wire dmart_pkg::sample_type     sample,
   output      logic signed [SUM_W-1:0]   sum
);

   localparam int POS_W = $clog2(LEN);

   logic [POS_W-1:0]        pos_ff, pos_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   dmart_pkg::sample_type   old_sample;
   logic signed [SUM_W-1:0] old_term;

   // Ring position: advance on each push, wrap at LEN
   always_comb begin
      pos_in = pos_ff;
      if (ctl.push) begin
         pos_in = (pos_ff == POS_W'(LEN - 1)) ? '0 : pos_ff + POS_W'(1);
      end
   end

   // Read address is the write position that follows any push in this cycle
   dmart_ram #(
      .WIDTH (dmart_pkg::SAMPLE_W),
      .DEPTH (LEN)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.push),
      .wr_addr (pos_ff),
      .wr_data (sample),
      .rd_addr (pos_in),
      .rd_data (old_sample)
   );

   // Running sum: add new sample, drop the replaced one (zero if never written)
   always_comb begin
      old_term = ctl.old_valid ? SUM_W'(old_sample) : '0;
      sum_in   = sum_ff;
      if (ctl.push) begin
         sum_in = sum_ff + SUM_W'(sample) - old_term;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

`default_nettype wire

// ----- rtl/dmart_avg.sv -----
// ----------------------------------------------------------------------------
// dmart_avg
// Window sum divided by LEN, truncated toward zero. The magnitude is scaled
// by a reciprocal wide enough that the quotient is exact over the sum range.
// ----------------------------------------------------------------------------
`default_nettype none

module dmart_avg #(
   parameter int LEN = 20,
   localparam int SUM_W = dmart_pkg::SAMPLE_W + $clog2(LEN)
) (
   input  wire logic signed [SUM_W-1:0] sum,
   output      dmart_pkg::sample_type   avg
);

   localparam int SHIFT   = SUM_W + $clog2(LEN);
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << SHIFT) + 64'(LEN) - 64'd1) / 64'(LEN));

   logic                  neg;
   logic [SUM_W-1:0]      mag;
   logic [PROD_W-1:0]     prod;
   dmart_pkg::sample_type quot;

   // |sum| * ceil(2^SHIFT / LEN) >> SHIFT, then restore the sign
   always_comb begin
      neg  = sum[SUM_W-1];
      mag  = neg ? SUM_W'(-sum) : SUM_W'(sum);
      prod = PROD_W'(mag) * PROD_W'(RECIP);
      quot = prod[SHIFT + dmart_pkg::SAMPLE_W - 1:SHIFT];
      avg  = neg ? -quot : quot;
   end

endmodule

`default_nettype wire

// ----- rtl/dual_moving_average_rssi_trigger_unit.sv -----
// ----------------------------------------------------------------------------
// dual_moving_average_rssi_trigger_unit
// Short/long moving-average crossover trigger on a stream of RSSI samples.
// ----------------------------------------------------------------------------
// One sample item is accepted per clock while the pipeline is not backed up.
// The first LONG_LEN items only fill the two windows and give no result.
// Every later item gives one result item. The window sums update at the
// accepting edge. The averages are formed by reciprocal multiplication and
// registered in the average stage; the ratio multiply and compare then load
// the result register. The windows are RAMs that read the entry to be
// replaced next ahead of the write, so every item replaces its oldest entry
// as it is accepted. A stage holds only while the one after it is full and
// cannot move on. The block keeps taking items as long as the pipeline has a
// free slot, and backs up into the input after three results wait.
// SHORT_LEN must not exceed LONG_LEN. Registers are to be written through the
// csr_ port only while no item is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_moving_average_rssi_trigger_unit #(
   parameter int SHORT_LEN = 20,
   parameter int LONG_LEN  = 100
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   dmart_req_if.sink                                 req_ch,
   dmart_rsp_if.source                               rsp_ch,
   input  wire logic                                 csr_we,
   input  wire logic [dmart_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [dmart_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SSUM_W  = dmart_pkg::SAMPLE_W + $clog2(SHORT_LEN);
   localparam int LSUM_W  = dmart_pkg::SAMPLE_W + $clog2(LONG_LEN);
   localparam int PRIME_W = $clog2(LONG_LEN + 1);
   localparam int CMP_W   = dmart_pkg::SAMPLE_W + dmart_pkg::RATIO_W + 1;

   // Configuration registers
   dmart_pkg::ratio_type ratio_ff;
   dmart_pkg::chan_type  target_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff  <= dmart_pkg::RATIO_RESET;
         target_ff <= dmart_pkg::TARGET_RESET;
      end else if (csr_we) begin
         unique case (dmart_pkg::csr_index_type'(csr_index))
            dmart_pkg::CSR_RATIO_Q8:
               ratio_ff <= csr_wdata[dmart_pkg::RATIO_W-1:0];
            dmart_pkg::CSR_TARGET_CHANNEL:
               target_ff <= csr_wdata[dmart_pkg::CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline flow control
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic en1, en2, en3, accept, primed;
   logic [PRIME_W-1:0] prime_ff, prime_in;

   always_comb begin
      en3    = !v3_ff || rsp_ch.ready;
      en2    = !v2_ff || en3;
      en1    = !v1_ff || en2;
      accept = req_ch.valid && en1;
      primed = (prime_ff == PRIME_W'(LONG_LEN));
      v1_in  = en1 ? (accept && primed) : v1_ff;
      v2_in  = en2 ? v1_ff : v2_ff;
      v3_in  = en3 ? v2_ff : v3_ff;
      prime_in = (accept && !primed) ? prime_ff + PRIME_W'(1) : prime_ff;
   end

   assign req_ch.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         prime_ff <= '0;
      end else begin
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         v3_ff    <= v3_in;
         prime_ff <= prime_in;
      end
   end

   // Windows: entries count as written once the fill count has passed them
   dmart_pkg::window_ctl_type short_ctl, long_ctl;
   logic signed [SSUM_W-1:0]  short_sum;
   logic signed [LSUM_W-1:0]  long_sum;

   always_comb begin
      short_ctl.push      = accept;
      short_ctl.old_valid = (prime_ff >= PRIME_W'(SHORT_LEN));
      long_ctl.push       = accept;
      long_ctl.old_valid  = primed;
   end

   dmart_window #(.LEN (SHORT_LEN)) u_short_win (
      .clock  (clock),
      .reset  (reset),
      .ctl    (short_ctl),
      .sample (req_ch.rssi_sample),
      .sum    (short_sum)
   );

   dmart_window #(.LEN (LONG_LEN)) u_long_win (
      .clock  (clock),
      .reset  (reset),
      .ctl    (long_ctl),
      .sample (req_ch.rssi_sample),
      .sum    (long_sum)
   );

   // Average stage
   dmart_pkg::sample_type short_avg_c, long_avg_c;
   dmart_pkg::sample_type short_avg_ff, long_avg_ff;

   dmart_avg #(.LEN (SHORT_LEN)) u_short_avg (
      .sum (short_sum),
      .avg (short_avg_c)
   );

   dmart_avg #(.LEN (LONG_LEN)) u_long_avg (
      .sum (long_sum),
      .avg (long_avg_c)
   );

   always_ff @(posedge clock) begin
      if (en2 && v1_ff) begin
         short_avg_ff <= short_avg_c;
         long_avg_ff  <= long_avg_c;
      end
   end

   // Compare stage: short_avg * ratio against long_avg * 256
   logic signed [CMP_W-1:0] short_scaled, long_scaled;
   logic                    switch_c;

   always_comb begin
      short_scaled = CMP_W'(short_avg_ff) * CMP_W'($signed({1'b0, ratio_ff}));
      long_scaled  = CMP_W'(long_avg_ff) <<< 8;
      switch_c     = (short_scaled > long_scaled);
   end

   // Result register
   dmart_pkg::sample_type rsp_short_ff, rsp_long_ff;
   logic                  rsp_switch_ff;
   dmart_pkg::chan_type   rsp_chan_ff;

   always_ff @(posedge clock) begin
      if (en3 && v2_ff) begin
         rsp_short_ff  <= short_avg_ff;
         rsp_long_ff   <= long_avg_ff;
         rsp_switch_ff <= switch_c;
         rsp_chan_ff   <= target_ff;
      end
   end

   assign rsp_ch.valid       = v3_ff;
   assign rsp_ch.short_avg   = rsp_short_ff;
   assign rsp_ch.long_avg    = rsp_long_ff;
   assign rsp_ch.switch_now  = rsp_switch_ff;
   assign rsp_ch.channel_out = rsp_chan_ff;

`ifndef ASSERT_OFF
   // No result may be in flight before the windows are full
   a_no_result_while_priming: assert property (@(posedge clock) disable iff (reset)
      (v1_ff || v2_ff || v3_ff) |-> primed)
      else $error("result in flight during priming");

   // A priming item never enters the result pipeline
   a_priming_item_dropped: assert property (@(posedge clock) disable iff (reset)
      (accept && !primed) |=> !v1_ff)
      else $error("priming item produced a result");

   // An item taken after priming always occupies the sum stage
   a_primed_item_tracked: assert property (@(posedge clock) disable iff (reset)
      (accept && primed) |=> v1_ff)
      else $error("primed item lost");

   // The fill count never runs past the long window length
   a_prime_bound: assert property (@(posedge clock) disable iff (reset)
      prime_ff <= PRIME_W'(LONG_LEN))
      else $error("fill count overrun");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the short/long moving-average RSSI trigger.
// ----------------------------------------------------------------------------
// Both windows are primed with full-scale negative samples. A short directed
// table of edge values follows, with the first result typed in by hand. Then
// come six random phases, each under its own ratio / channel setting: slowly
// moving levels with noise and steps, full-range noise and rail-to-rail
// swings. Every later result is checked against a local copy of the window
// arithmetic. Both handshakes idle in random bursts. One long receiver hold
// backs the pipeline up into the input. The last phase runs with no idling.
// ----------------------------------------------------------------------------

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SHORT_DEPTH  = 20;
   localparam int LONG_DEPTH   = 100;
   localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake at all
   localparam int DRAIN_CYCLES = 8;     // pipeline is three deep
   localparam int HOLD_CYCLES  = 60;

   typedef struct packed {
      dmart_pkg::sample_type short_avg;
      dmart_pkg::sample_type long_avg;
      logic                  switch_now;
      dmart_pkg::chan_type   channel_out;
   } trigger_type;

   typedef struct {
      dmart_pkg::sample_type sample;
      bit                    typed;     // use exp instead of the predictor
      trigger_type           exp;
   } directed_row_type;

   typedef enum int {
      MODE_SPREAD,   // uniform over the full range
      MODE_LEVEL,    // level with small noise, stepping now and then
      MODE_EXTREME   // rails only
   } stim_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [dmart_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [dmart_pkg::CSR_DATA_W-1:0] csr_wdata;

   dmart_req_if req_ch ();
   dmart_rsp_if rsp_ch ();

   dual_moving_average_rssi_trigger_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Local window state and register shadows
   dmart_pkg::sample_type short_ring [SHORT_DEPTH];
   dmart_pkg::sample_type long_ring  [LONG_DEPTH];
   int                    short_acc, long_acc;
   int                    short_head, long_head, fill_count;
   dmart_pkg::ratio_type  ratio_shadow   = dmart_pkg::RATIO_RESET;
   dmart_pkg::chan_type   channel_shadow = dmart_pkg::TARGET_RESET;

   trigger_type pending_triggers [$];

   int  error_count    = 0;
   int  samples_sent   = 0;
   int  triggers_seen  = 0;
   int  switch_seen    = 0;
   int  settings_used  = 0;
   bit  quiet_tail     = 1'b0;
   bit  hold_receiver  = 1'b0;

   // Push one sample into both rings; returns 1 when a result is due
   function automatic bit shift_in_sample(input dmart_pkg::sample_type s,
                                          output trigger_type r);
      int sa;
      int la;
      short_acc += int'(s) - int'(short_ring[short_head]);
      short_ring[short_head] = s;
      long_acc += int'(s) - int'(long_ring[long_head]);
      long_ring[long_head] = s;
      short_head = (short_head + 1 >= SHORT_DEPTH) ? 0 : short_head + 1;
      long_head  = (long_head + 1 >= LONG_DEPTH) ? 0 : long_head + 1;
      r = '0;
      if (fill_count < LONG_DEPTH) begin
         fill_count++;
         return 1'b0;
      end
      // SV integer division truncates toward zero, as required
      sa = short_acc / SHORT_DEPTH;
      la = long_acc / LONG_DEPTH;
      r.short_avg   = dmart_pkg::sample_type'(sa);
      r.long_avg    = dmart_pkg::sample_type'(la);
      r.switch_now  = (sa * int'(ratio_shadow)) > (la * 256);
      r.channel_out = channel_shadow;
      return 1'b1;
   endfunction

   function automatic dmart_pkg::sample_type draw_sample(input stim_mode_type mode,
                                                          input int level);
      int v;
      case (mode)
         MODE_SPREAD:  v = int'($urandom_range(0, 255)) - 128;
         MODE_LEVEL:   v = level + int'($urandom_range(0, 8)) - 4;
         default:      v = ($urandom_range(0, 1) != 0) ? 127 : -128;
      endcase
      if (v > 127) v = 127;
      if (v < -128) v = -128;
      return dmart_pkg::sample_type'(v);
   endfunction

   // Offer one sample item; called and returns at a falling edge
   task automatic send_sample(input dmart_pkg::sample_type s, input bit typed,
                              input trigger_type exp);
      trigger_type predicted;
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.rssi_sample <= s;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (shift_in_sample(s, predicted))
         pending_triggers.push_back(typed ? exp : predicted);
      samples_sent++;
      @(negedge clock);
   endtask

   // Let every in-flight item come out before touching registers
   task automatic drain_pipeline();
      while (pending_triggers.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input dmart_pkg::csr_index_type idx,
                                 input logic [dmart_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         dmart_pkg::CSR_RATIO_Q8:       ratio_shadow   = dmart_pkg::ratio_type'(data);
         dmart_pkg::CSR_TARGET_CHANNEL: channel_shadow = dmart_pkg::chan_type'(data);
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic run_phase(input logic [dmart_pkg::CSR_DATA_W-1:0] ratio,
                            input logic [dmart_pkg::CSR_DATA_W-1:0] channel,
                            input stim_mode_type mode, input int count, input bit with_hold);
      int level;
      drain_pipeline();
      write_register(dmart_pkg::CSR_RATIO_Q8, ratio);
      write_register(dmart_pkg::CSR_TARGET_CHANNEL, channel);
      settings_used++;
      level = int'($urandom_range(0, 240)) - 120;
      for (int i = 0; i < count; i++) begin
         // step the level so the short window leads the long one
         if (mode == MODE_LEVEL && i % 25 == 24)
            level = int'($urandom_range(0, 240)) - 120;
         if (with_hold && i == count / 2)
            hold_receiver = 1'b1;
         send_sample(draw_sample(mode, level), 1'b0, '0);
      end
      req_ch.valid <= 1'b0;
   endtask

   // Result side: random ready bursts, plus one long hold on request
   initial begin
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (hold_receiver) begin
            hold_receiver = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      trigger_type exp;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_triggers.size() == 0) begin
            $error("unexpected result item: short_avg %0d long_avg %0d",
                   rsp_ch.short_avg, rsp_ch.long_avg);
            error_count++;
         end else begin
            exp = pending_triggers.pop_front();
            triggers_seen++;
            if (rsp_ch.switch_now === 1'b1) switch_seen++;
            if (rsp_ch.short_avg !== exp.short_avg) begin
               $error("short_avg: expected %0d, actual %0d", exp.short_avg, rsp_ch.short_avg);
               error_count++;
            end
            if (rsp_ch.long_avg !== exp.long_avg) begin
               $error("long_avg: expected %0d, actual %0d", exp.long_avg, rsp_ch.long_avg);
               error_count++;
            end
            if (rsp_ch.switch_now !== exp.switch_now) begin
               $error("switch_now: expected %0b, actual %0b", exp.switch_now,
                      rsp_ch.switch_now);
               error_count++;
            end
            if (rsp_ch.channel_out !== exp.channel_out) begin
               $error("channel_out: expected %0d, actual %0d", exp.channel_out,
                      rsp_ch.channel_out);
               error_count++;
            end
         end
      end
   end

   // Watchdog: too long with no handshake on either side
   int stall_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
         $display("** dual_moving_average_rssi_trigger_unit: FAILED **");
         $finish;
      end
   end

   // Main sequence
   directed_row_type directed_rows [18];

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.rssi_sample = '0;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      foreach (short_ring[i]) short_ring[i] = '0;
      foreach (long_ring[i])  long_ring[i]  = '0;
      short_acc   = 0;
      long_acc    = 0;
      short_head  = 0;
      long_head   = 0;
      fill_count  = 0;

      // After priming with -128, the first result is all -128, switch clear
      directed_rows = '{
         '{-8'sd128, 1'b1, '{-8'sd128, -8'sd128, 1'b0, 5'd17}},
         '{8'sd127,  1'b0, '0}, '{8'sd127,  1'b0, '0}, '{8'sd127,  1'b0, '0},
         '{8'sd0,    1'b0, '0}, '{-8'sd1,   1'b0, '0}, '{8'sd1,    1'b0, '0},
         '{-8'sd1,   1'b0, '0}, '{8'sd127,  1'b0, '0}, '{-8'sd128, 1'b0, '0},
         '{-8'sd127, 1'b0, '0}, '{8'sd126,  1'b0, '0}, '{8'sd64,   1'b0, '0},
         '{-8'sd64,  1'b0, '0}, '{8'sd85,   1'b0, '0}, '{-8'sd85,  1'b0, '0},
         '{8'sd0,    1'b0, '0}, '{8'sd127,  1'b0, '0}
      };

      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Priming under reset register values: no results may appear
      for (int i = 0; i < LONG_DEPTH; i++)
         send_sample(-8'sd128, 1'b0, '0);
      foreach (directed_rows[i])
         send_sample(directed_rows[i].sample, directed_rows[i].typed, directed_rows[i].exp);
      req_ch.valid <= 1'b0;

      // Random phases across register settings, extremes included
      run_phase(10'd0,    10'd11, MODE_LEVEL,   50, 1'b0);
      run_phase(10'd1023, 10'd26, MODE_SPREAD,  50, 1'b1);
      run_phase(10'd256,  10'd31, MODE_LEVEL,   50, 1'b0);
      run_phase(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                MODE_EXTREME, 50, 1'b0);
      run_phase(10'd282,  10'd0,  MODE_LEVEL,   50, 1'b0);
      drain_pipeline();
      quiet_tail = 1'b1;
      run_phase(10'($urandom_range(0, 1023)), 10'($urandom_range(11, 26)),
                MODE_SPREAD, 50, 1'b0);

      drain_pipeline();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d samples (priming, edge values, levels, steps, noise, rails);",
               samples_sent);
      $display("checked %0d results, %0d with switch set, over %0d register settings.",
               triggers_seen, switch_seen, settings_used + 1);
      if (error_count == 0)
         $display("** dual_moving_average_rssi_trigger_unit: PASSED **");
      else
         $display("** dual_moving_average_rssi_trigger_unit: FAILED **");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/dmart_pkg.sv
rtl/dmart_ifs.sv
rtl/dmart_ram.sv
rtl/dmart_window.sv
rtl/dmart_avg.sv
rtl/dual_moving_average_rssi_trigger_unit.sv
tb/sv/tb.sv
